[rtl/core/profile_parabolic_interpolator_core_macros.svh]
// assertion helpers, clocked on clock and disabled during reset
`ifndef PROFILE_PARABOLIC_INTERPOLATOR_CORE_MACROS_SVH
`define PROFILE_PARABOLIC_INTERPOLATOR_CORE_MACROS_SVH

// same-cycle implication
`define PPI_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ppi_pkg.sv]
package ppi_pkg;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_INTERP = 2'd2;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_BELOW  = 3'd1;
   localparam logic [2:0] ST_ABOVE  = 3'd2;
   localparam logic [2:0] ST_TOOFEW = 3'd3;
   localparam logic [2:0] ST_DEGEN  = 3'd4;

   localparam int DIV_STEPS = 64;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   localparam logic signed [63:0] SLOPE_LIM = 64'sd70368744177663;
   localparam logic signed [63:0] S64_MAX   = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN   = {1'b1, {63{1'b0}}};

   typedef struct packed {
      logic        [1:0]  opcode;
      logic        [7:0]  node_index;
      logic signed [31:0] position_in;
      logic signed [31:0] value_in;
   } ppi_req_type;

   typedef struct packed {
      logic signed [31:0] value_out;
      logic signed [31:0] position_out;
      logic        [2:0]  status;
   } ppi_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_RD_WAIT, S_LAST_WAIT, S_FIRST_WAIT, S_SEARCH, S_MID_WAIT,
      S_BASE, S_N0_WAIT, S_N1_WAIT, S_N2_WAIT, S_DIFF, S_DIV_LOAD, S_DIV_RUN,
      S_DIV_END, S_MUL_LOAD, S_MUL_LO, S_MUL_HI, S_MUL_ACC, S_MUL_END, S_DONE
   } ppi_state_type;

   function automatic logic signed [32:0] diff33(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      return {a[31], a} - {b[31], b};
   endfunction

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? S64_MIN : S64_MAX;
      end
      return s;
   endfunction

   function automatic logic signed [63:0] clamp_slope(input logic signed [63:0] v);
      if (v > SLOPE_LIM) begin
         return SLOPE_LIM;
      end
      if (v < -SLOPE_LIM) begin
         return -SLOPE_LIM;
      end
      return v;
   endfunction

   // product magnitude >> 16, signed and saturated to 64 bits
   function automatic logic signed [63:0] mul_finish(input logic [95:0] prod,
                                                    input logic neg);
      logic [63:0] sh;
      sh = prod[79:16];
      if (prod[95:80] != 16'd0) begin
         return neg ? S64_MIN : S64_MAX;
      end
      if (neg) begin
         return sh[63] ? S64_MIN : $signed(64'd0 - sh);
      end
      return sh[63] ? S64_MAX : $signed(sh);
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

[rtl/core/profile_parabolic_interpolator_core.sv]
// channel  | ports                                | dir | meaning
// ---------+--------------------------------------+-----+-------------------------------
// request  | req_valid, req_ready, req_data       | in  | write, read or interpolate item
// response | rsp_valid, rsp_ready, rsp_data       | out | one result item per request
// csr      | csr_wr_en, csr_wr_data               | in  | node_count register
//
// write, read and unused opcode: result sits in an output register
// interpolate: binary node search, then three 64-step restoring divisions
// on one shared divider plus two 2-pass 32x32 multiplies and serial table reads
// one item at a time: req_ready only in idle, which the fsm re-enters as the result loads
// reset (synchronous) clears fsm, response valid and node_count; tables are not cleared
`include "profile_parabolic_interpolator_core_macros.svh"

module profile_parabolic_interpolator_core
   import ppi_pkg::*;
#(
   parameter int MAX_NODES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ppi_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ppi_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);

   localparam int AW = $clog2(MAX_NODES);
   localparam int NW = (AW + 1 > 9) ? AW + 1 : 9;

   ppi_state_type state_ff, state_in;
   ppi_req_type   req_ff, req_in;
   ppi_rsp_type   rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [8:0]    node_count_ff, node_count_in;

   logic signed [31:0] pos_mem_ff [MAX_NODES];
   logic signed [31:0] val_mem_ff [MAX_NODES];
   logic signed [31:0] pos_rd_ff, val_rd_ff;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               mem_we;

   logic signed [31:0] x_ff, x_in, plast_ff, plast_in, pl_ff, pl_in, pr_ff, pr_in;
   logic [AW-1:0]      lft_ff, lft_in, rgt_ff, rgt_in, mid_ff, mid_in;
   logic [AW-1:0]      k_ff, k_in, i0_ff, i0_in;
   logic signed [31:0] x0_ff, x0_in, x1_ff, x1_in, x2_ff, x2_in;
   logic signed [31:0] f0_ff, f0_in, f1_ff, f1_in, f2_ff, f2_in;
   logic signed [63:0] s0_ff, s0_in, s1_ff, s1_in, c_ff, c_in, inner_ff, inner_in;
   logic [1:0]         sel_ff, sel_in;
   logic [63:0]        dvd_ff, dvd_in;
   logic [31:0]        dvs_ff, dvs_in, rem_ff, rem_in;
   logic [DIV_CW-1:0]  cnt_ff, cnt_in;
   logic               qneg_ff, qneg_in;
   logic [63:0]        ma_ff, ma_in, pp_ff, pp_in;
   logic [31:0]        mb_ff, mb_in;
   logic               mneg_ff, mneg_in;
   logic [95:0]        prod_ff, prod_in;
   logic signed [31:0] res_val_ff, res_val_in, res_pos_ff, res_pos_in;
   logic [2:0]         res_st_ff, res_st_in;

   logic [NW-1:0] count_ext, n_eff, n_m1, idx_ext;
   logic [AW-1:0] last_idx;

   assign count_ext = NW'(node_count_ff);
   assign n_eff     = (count_ext > NW'(MAX_NODES)) ? NW'(MAX_NODES) : count_ext;
   assign n_m1      = n_eff - NW'(1);
   assign last_idx  = n_m1[AW-1:0];
   assign idx_ext   = NW'(req_ff.node_index);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         node_count_ff <= node_count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      x_ff       <= x_in;
      plast_ff   <= plast_in;
      pl_ff      <= pl_in;
      pr_ff      <= pr_in;
      lft_ff     <= lft_in;
      rgt_ff     <= rgt_in;
      mid_ff     <= mid_in;
      k_ff       <= k_in;
      i0_ff      <= i0_in;
      x0_ff      <= x0_in;
      x1_ff      <= x1_in;
      x2_ff      <= x2_in;
      f0_ff      <= f0_in;
      f1_ff      <= f1_in;
      f2_ff      <= f2_in;
      s0_ff      <= s0_in;
      s1_ff      <= s1_in;
      c_ff       <= c_in;
      inner_ff   <= inner_in;
      sel_ff     <= sel_in;
      dvd_ff     <= dvd_in;
      dvs_ff     <= dvs_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      qneg_ff    <= qneg_in;
      ma_ff      <= ma_in;
      mb_ff      <= mb_in;
      mneg_ff    <= mneg_in;
      pp_ff      <= pp_in;
      prod_ff    <= prod_in;
      res_val_ff <= res_val_in;
      res_pos_ff <= res_pos_in;
      res_st_ff  <= res_st_in;
   end

   // node tables
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pos_mem_ff[wr_addr] <= req_ff.position_in;
         val_mem_ff[wr_addr] <= req_ff.value_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_rd_ff <= pos_mem_ff[rd_addr];
      val_rd_ff <= val_mem_ff[rd_addr];
   end

   always_comb begin
      logic [AW:0]        mid_sum;
      logic signed [32:0] dl_s, dr_s, h0, h1, h2, dn, db;
      logic [32:0]        dl, dr;
      logic signed [63:0] num, ds, q, ma_s, mres, rsum;
      logic [32:0]        rem_sh;
      logic               ge;

      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;
      rd_addr       = '0;
      wr_addr       = idx_ext[AW-1:0];
      mem_we        = 1'b0;
      x_in          = x_ff;
      plast_in      = plast_ff;
      pl_in         = pl_ff;
      pr_in         = pr_ff;
      lft_in        = lft_ff;
      rgt_in        = rgt_ff;
      mid_in        = mid_ff;
      k_in          = k_ff;
      i0_in         = i0_ff;
      x0_in         = x0_ff;
      x1_in         = x1_ff;
      x2_in         = x2_ff;
      f0_in         = f0_ff;
      f1_in         = f1_ff;
      f2_in         = f2_ff;
      s0_in         = s0_ff;
      s1_in         = s1_ff;
      c_in          = c_ff;
      inner_in      = inner_ff;
      sel_in        = sel_ff;
      dvd_in        = dvd_ff;
      dvs_in        = dvs_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      qneg_in       = qneg_ff;
      ma_in         = ma_ff;
      mb_in         = mb_ff;
      mneg_in       = mneg_ff;
      pp_in         = pp_ff;
      prod_in       = prod_ff;
      res_val_in    = res_val_ff;
      res_pos_in    = res_pos_ff;
      res_st_in     = res_st_ff;

      mid_sum = {1'b0, lft_ff} + {1'b0, rgt_ff};
      dl_s    = diff33(x_ff, pl_ff);
      dr_s    = diff33(x_ff, pr_ff);
      dl      = dl_s[32] ? 33'(-dl_s) : 33'(dl_s);
      dr      = dr_s[32] ? 33'(-dr_s) : 33'(dr_s);
      h0      = diff33(x1_ff, x0_ff);
      h1      = diff33(x2_ff, x1_ff);
      h2      = diff33(x2_ff, x0_ff);
      dn      = '0;
      db      = '0;
      num     = '0;
      ds      = s1_ff - s0_ff;
      q       = qneg_ff ? -$signed(dvd_ff) : $signed(dvd_ff);
      ma_s    = '0;
      mres    = mul_finish(prod_ff, mneg_ff);
      rsum    = '0;
      rem_sh  = {rem_ff, dvd_ff[63]};
      ge      = rem_sh >= {1'b0, dvs_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_val_in = '0;
            res_pos_in = '0;
            res_st_in  = ST_OK;
            state_in   = S_DONE;
            case (req_ff.opcode)
               OP_WRITE: begin
                  mem_we = (idx_ext < NW'(MAX_NODES));
               end
               OP_READ: begin
                  if (n_eff == '0) begin
                     res_st_in = ST_TOOFEW;
                  end else begin
                     if (idx_ext >= n_eff) begin
                        rd_addr   = last_idx;
                        res_st_in = ST_ABOVE;
                     end else begin
                        rd_addr = idx_ext[AW-1:0];
                     end
                     state_in = S_RD_WAIT;
                  end
               end
               OP_INTERP: begin
                  if (n_eff == '0) begin
                     res_st_in = ST_TOOFEW;
                  end else begin
                     rd_addr  = last_idx;
                     state_in = S_LAST_WAIT;
                  end
               end
               default: begin
               end
            endcase
         end
         S_RD_WAIT: begin
            res_val_in = val_rd_ff;
            res_pos_in = pos_rd_ff;
            state_in   = S_DONE;
         end
         S_LAST_WAIT: begin
            plast_in = pos_rd_ff;
            if (!req_ff.position_in[31] && req_ff.position_in > pos_rd_ff) begin
               res_val_in = val_rd_ff;
               res_pos_in = pos_rd_ff;
               res_st_in  = ST_ABOVE;
               state_in   = S_DONE;
            end else begin
               x_in       = req_ff.position_in[31] ? '0 : req_ff.position_in;
               res_pos_in = req_ff.position_in[31] ? '0 : req_ff.position_in;
               res_st_in  = req_ff.position_in[31] ? ST_BELOW : ST_OK;
               if (n_eff <= NW'(3)) begin
                  res_st_in = ST_TOOFEW;
                  state_in  = S_DONE;
               end else begin
                  rd_addr  = '0;
                  state_in = S_FIRST_WAIT;
               end
            end
         end
         S_FIRST_WAIT: begin
            if (x_ff <= pos_rd_ff) begin
               k_in     = '0;
               state_in = S_BASE;
            end else if (x_ff >= plast_ff) begin
               k_in     = last_idx;
               state_in = S_BASE;
            end else begin
               lft_in   = '0;
               rgt_in   = last_idx;
               pl_in    = pos_rd_ff;
               pr_in    = plast_ff;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (rgt_ff - lft_ff > AW'(1)) begin
               mid_in   = mid_sum[AW:1];
               rd_addr  = mid_sum[AW:1];
               state_in = S_MID_WAIT;
            end else begin
               // ties go to the upper node
               k_in     = (dl < dr) ? lft_ff : rgt_ff;
               state_in = S_BASE;
            end
         end
         S_MID_WAIT: begin
            if (x_ff >= pos_rd_ff) begin
               lft_in = mid_ff;
               pl_in  = pos_rd_ff;
            end else begin
               rgt_in = mid_ff;
               pr_in  = pos_rd_ff;
            end
            state_in = S_SEARCH;
         end
         S_BASE: begin
            // three nodes, shifted inward at either end
            if (k_ff == '0) begin
               i0_in = '0;
            end else if (k_ff == last_idx) begin
               i0_in = last_idx - AW'(2);
            end else begin
               i0_in = k_ff - AW'(1);
            end
            rd_addr  = i0_in;
            state_in = S_N0_WAIT;
         end
         S_N0_WAIT: begin
            x0_in    = pos_rd_ff;
            f0_in    = val_rd_ff;
            rd_addr  = i0_ff + AW'(1);
            state_in = S_N1_WAIT;
         end
         S_N1_WAIT: begin
            x1_in    = pos_rd_ff;
            f1_in    = val_rd_ff;
            rd_addr  = i0_ff + AW'(2);
            state_in = S_N2_WAIT;
         end
         S_N2_WAIT: begin
            x2_in    = pos_rd_ff;
            f2_in    = val_rd_ff;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            if (h0 == '0 || h1 == '0 || h2 == '0) begin
               res_val_in = '0;
               res_st_in  = ST_DEGEN;
               state_in   = S_DONE;
            end else begin
               sel_in   = 2'd0;
               state_in = S_DIV_LOAD;
            end
         end
         S_DIV_LOAD: begin
            case (sel_ff)
               2'd0: begin
                  dn  = diff33(f1_ff, f0_ff);
                  num = {{15{dn[32]}}, dn, 16'd0};
                  db  = h0;
               end
               2'd1: begin
                  dn  = diff33(f2_ff, f1_ff);
                  num = {{15{dn[32]}}, dn, 16'd0};
                  db  = h1;
               end
               default: begin
                  num = {ds[47:0], 16'd0};
                  db  = h2;
               end
            endcase
            dvd_in   = num[63] ? 64'(-num) : 64'(num);
            dvs_in   = db[32] ? 32'(-db) : db[31:0];
            qneg_in  = num[63] ^ db[32];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV_RUN;
         end
         S_DIV_RUN: begin
            rem_in = ge ? 32'(rem_sh - {1'b0, dvs_ff}) : rem_sh[31:0];
            dvd_in = {dvd_ff[62:0], ge};
            cnt_in = cnt_ff + DIV_CW'(1);
            if (cnt_ff == DIV_CW'(DIV_STEPS - 1)) begin
               state_in = S_DIV_END;
            end
         end
         S_DIV_END: begin
            case (sel_ff)
               2'd0: begin
                  s0_in    = clamp_slope(q);
                  sel_in   = 2'd1;
                  state_in = S_DIV_LOAD;
               end
               2'd1: begin
                  s1_in    = clamp_slope(q);
                  sel_in   = 2'd2;
                  state_in = S_DIV_LOAD;
               end
               default: begin
                  c_in     = q;
                  sel_in   = 2'd0;
                  state_in = S_MUL_LOAD;
               end
            endcase
         end
         S_MUL_LOAD: begin
            if (sel_ff == 2'd0) begin
               ma_s = c_ff;
               db   = diff33(x_ff, x1_ff);
            end else begin
               ma_s = inner_ff;
               db   = diff33(x_ff, x0_ff);
            end
            ma_in    = ma_s[63] ? 64'(-ma_s) : 64'(ma_s);
            mb_in    = db[32] ? 32'(-db) : db[31:0];
            mneg_in  = ma_s[63] ^ db[32];
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            pp_in    = 64'(ma_ff[31:0]) * 64'(mb_ff);
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            prod_in  = {32'd0, pp_ff};
            pp_in    = 64'(ma_ff[63:32]) * 64'(mb_ff);
            state_in = S_MUL_ACC;
         end
         S_MUL_ACC: begin
            prod_in  = prod_ff + {pp_ff, 32'd0};
            state_in = S_MUL_END;
         end
         S_MUL_END: begin
            if (sel_ff == 2'd0) begin
               inner_in = sat_add64(s0_ff, mres);
               sel_in   = 2'd1;
               state_in = S_MUL_LOAD;
            end else begin
               rsum       = sat_add64({{32{f0_ff[31]}}, f0_ff}, mres);
               res_val_in = clamp32(rsum);
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.value_out    = res_val_ff;
               rsp_in.position_out = res_pos_ff;
               rsp_in.status       = res_st_ff;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `PPI_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "item taken while busy")
   `PPI_ASSERT_SAME(a_search_order, state_ff == S_SEARCH, lft_ff < rgt_ff, "search bounds crossed")
   `PPI_ASSERT_SAME(a_divisor_nonzero, state_ff == S_DIV_RUN, dvs_ff != '0, "divide by zero")
   `PPI_ASSERT_NEXT(a_result_loaded, state_ff == S_DONE && (!rsp_valid_ff || rsp_ready), rsp_valid && req_ready, "result not loaded")

endmodule

[dv/profile_parabolic_interpolator_core_tb.sv]
`timescale 1ns / 100ps

module profile_parabolic_interpolator_core_tb;
   import ppi_pkg::*;

   localparam int TABLE_DEPTH = 256;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ppi_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ppi_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [8:0]  csr_wr_data = '0;

   ppi_req_type pending_items[$];
   ppi_rsp_type expected_results[$];

   logic signed [31:0] node_pos[TABLE_DEPTH];
   logic signed [31:0] node_val[TABLE_DEPTH];
   logic [8:0] node_count_reg = '0;

   int  mismatch_count = 0;
   bit  calm = 1'b0;
   bit  hold_go = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;

   profile_parabolic_interpolator_core #(.MAX_NODES(TABLE_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic longint add_sat(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? S64_MIN : S64_MAX;
      end
      return s;
   endfunction

   function automatic longint fix_mul(longint a, longint b);
      logic [63:0]  ma, mb, sh;
      logic [127:0] prod;
      bit neg;
      neg  = (a < 0) != (b < 0);
      ma   = a < 0 ? 64'd0 - a : a;
      mb   = b < 0 ? 64'd0 - b : b;
      prod = {64'd0, ma} * {64'd0, mb};
      sh   = prod[79:16];
      if (prod[127:80] != 0) begin
         return neg ? S64_MIN : S64_MAX;
      end
      if (neg) begin
         return sh[63] ? S64_MIN : -$signed(sh);
      end
      return sh[63] ? S64_MAX : $signed(sh);
   endfunction

   function automatic longint slope_clamp(longint v);
      if (v > SLOPE_LIM) begin
         return SLOPE_LIM;
      end
      if (v < -SLOPE_LIM) begin
         return -SLOPE_LIM;
      end
      return v;
   endfunction

   function automatic int nearest_node(longint x, int n);
      int lft, rgt, mid;
      longint dl, dr;
      lft = 0;
      rgt = n - 1;
      if (x <= node_pos[0]) begin
         return 0;
      end
      if (x >= node_pos[n-1]) begin
         return n - 1;
      end
      while (rgt - lft > 1) begin
         mid = (lft + rgt) / 2;
         if (x >= node_pos[mid]) lft = mid; else rgt = mid;
      end
      dl = x - node_pos[lft];
      dr = x - node_pos[rgt];
      if (dl < 0) dl = -dl;
      if (dr < 0) dr = -dr;
      return dl < dr ? lft : rgt;
   endfunction

   // returns 1 when the chosen nodes share a position
   function automatic bit eval_parabola(longint x, int n, output logic signed [31:0] res);
      int k, i0;
      longint x0, x1, x2, f0, f1, f2, h0, h1, h2, s0, s1, c, inner, p, r;
      k = nearest_node(x, n);
      if (k == 0) i0 = 0;
      else if (k == n - 1) i0 = n - 3;
      else i0 = k - 1;
      x0 = node_pos[i0]; x1 = node_pos[i0+1]; x2 = node_pos[i0+2];
      f0 = node_val[i0]; f1 = node_val[i0+1]; f2 = node_val[i0+2];
      h0 = x1 - x0; h1 = x2 - x1; h2 = x2 - x0;
      res = '0;
      if (h0 == 0 || h1 == 0 || h2 == 0) begin
         return 1'b1;
      end
      s0 = slope_clamp(((f1 - f0) * 65536) / h0);
      s1 = slope_clamp(((f2 - f1) * 65536) / h1);
      c = ((s1 - s0) * 65536) / h2;
      inner = add_sat(s0, fix_mul(c, x - x1));
      p = fix_mul(inner, x - x0);
      r = add_sat(f0, p);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      res = r[31:0];
      return 1'b0;
   endfunction

   function automatic ppi_rsp_type predict_result(ppi_req_type r);
      ppi_rsp_type o;
      int n, idx;
      longint q;
      logic signed [31:0] v;
      o = '0;
      n = node_count_reg > TABLE_DEPTH ? TABLE_DEPTH : int'(node_count_reg);
      idx = int'(r.node_index);
      q = longint'(r.position_in);
      case (r.opcode)
         OP_WRITE: begin
            node_pos[idx] = r.position_in;
            node_val[idx] = r.value_in;
         end
         OP_READ: begin
            if (n == 0) begin
               o.status = ST_TOOFEW;
            end else begin
               if (idx >= n) begin
                  idx = n - 1;
                  o.status = ST_ABOVE;
               end
               o.value_out = node_val[idx];
               o.position_out = node_pos[idx];
            end
         end
         OP_INTERP: begin
            if (n == 0) begin
               o.status = ST_TOOFEW;
            end else if (q >= 0 && q > node_pos[n-1]) begin
               o.value_out = node_val[n-1];
               o.position_out = node_pos[n-1];
               o.status = ST_ABOVE;
            end else begin
               if (q < 0) begin
                  q = 0;
                  o.status = ST_BELOW;
               end
               o.position_out = q[31:0];
               if (n <= 3) begin
                  o.status = ST_TOOFEW;
               end else if (eval_parabola(q, n, v)) begin
                  o.status = ST_DEGEN;
               end else begin
                  o.value_out = v;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      ppi_req_type nxt;
      logic nv;
      nv = req_valid;
      nxt = req_data;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.insert(expected_results.size(), predict_result(req_data));
            nv = 1'b0;
         end
         if (!nv && pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 25)) begin
            nxt = pending_items.pop_front();
            nv = 1'b1;
         end
      end
      req_valid <= nv;
      req_data <= nxt;
   end

   // receiver pacing
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_left <= 600;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_ready <= !reset && hold_left <= 1 && !(hold_go && !hold_done)
                   && (calm || $urandom_range(0, 99) >= 25);
   end

   // monitor
   always @(posedge clock) begin
      ppi_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected item: value %h position %h status %0d",
                        rsp_data.value_out, rsp_data.position_out, rsp_data.status);
            end
         end else begin
            want = expected_results.pop_front();
            if (want.value_out !== rsp_data.value_out
                || want.position_out !== rsp_data.position_out
                || want.status !== rsp_data.status) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected value %h position %h status %0d, got %h %h %0d",
                           want.value_out, want.position_out, want.status,
                           rsp_data.value_out, rsp_data.position_out, rsp_data.status);
               end
            end
         end
      end
   end

   task automatic queue_item(logic [1:0] op, logic [7:0] idx, logic [31:0] pos,
                             logic [31:0] val);
      ppi_req_type r;
      r.opcode = op;
      r.node_index = idx;
      r.position_in = pos;
      r.value_in = val;
      pending_items.insert(pending_items.size(), r);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_node_count(logic [8:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      node_count_reg = v;
      @(posedge clock);
   endtask

   // query near a node, midway to the next, or anywhere
   function automatic logic [31:0] pick_query(int n, logic signed [31:0] shadow_pos[TABLE_DEPTH]);
      int j, sel;
      longint a, b;
      sel = $urandom_range(0, 9);
      j = $urandom_range(0, n - 1);
      a = longint'(shadow_pos[j]);
      b = (j + 1 < n) ? longint'(shadow_pos[j+1]) : a + 2;
      if (sel < 4) return 32'(a + $signed($urandom_range(0, 8191)) - 4096);
      if (sel < 6) return 32'((a + b) / 2);
      if (sel == 6) return 32'(a + ((b - a) * $urandom_range(0, 100)) / 100);
      if (sel == 7) return 32'(-$signed({1'b0, $urandom_range(0, 65535)}));
      return $urandom;
   endfunction

   initial begin
      logic signed [31:0] shadow_pos[TABLE_DEPTH];
      longint p;
      int n, op;
      logic [8:0] counts[8];
      counts = '{9'd256, 9'd4, 9'd5, 9'd17, 9'd100, 9'd256, 9'd64, 9'd255};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_node_count(9'd0);
      // empty table and unused opcode
      queue_item(OP_READ, 8'd0, 32'd0, 32'd0);
      queue_item(OP_INTERP, 8'd0, 32'd1000, 32'd0);
      queue_item(2'd3, 8'hff, 32'hffffffff, 32'hffffffff);
      // fill every entry, increasing positions
      p = -$signed({1'b0, $urandom_range(0, 200000)});
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         shadow_pos[i] = 32'(p);
         queue_item(OP_WRITE, 8'(i), 32'(p), $urandom_range(0, 1) ? $urandom
                    : $signed($urandom_range(0, 400000)) - 200000);
         p += $urandom_range(1, 400000);
      end
      wait_idle();
      for (int c = 1; c <= 4; c++) begin
         set_node_count(9'(c));
         queue_item(OP_READ, 8'd200, 32'd0, 32'd0);
         queue_item(OP_INTERP, 8'd0, 32'h7fffffff, 32'd0);
         queue_item(OP_INTERP, 8'd0, 32'h80000000, 32'd0);
         queue_item(OP_INTERP, 8'd0, shadow_pos[c-1], 32'd0);
         wait_idle();
      end
      set_node_count(9'd256);
      queue_item(OP_READ, 8'd255, 32'd0, 32'd0);
      queue_item(OP_READ, 8'd0, 32'd0, 32'd0);
      queue_item(OP_INTERP, 8'd0, shadow_pos[0], 32'd0);
      queue_item(OP_INTERP, 8'd0, shadow_pos[255], 32'd0);
      queue_item(OP_INTERP, 8'd0,
                 32'((longint'(shadow_pos[9]) + shadow_pos[10]) / 2), 32'd0);
      queue_item(OP_INTERP, 8'd0, 32'hfffffff0, 32'd0);
      wait_idle();
      // extreme nodes near the front, with a repeated position
      for (int i = 0; i < 8; i++) begin
         shadow_pos[i] = (i == 3) ? shadow_pos[2] : (i * 32'h0fffffff);
         queue_item(OP_WRITE, 8'(i), shadow_pos[i], (i % 2) ? 32'h7fffffff : 32'h80000000);
      end
      wait_idle();
      set_node_count(9'd8);
      for (int i = 0; i < 12; i++) begin
         queue_item(OP_INTERP, 8'd0, pick_query(8, shadow_pos), 32'd0);
      end
      wait_idle();
      for (int i = 0; i < 8; i++) begin
         shadow_pos[i] = i * $urandom_range(1, 32'h00ffffff);
         queue_item(OP_WRITE, 8'(i), shadow_pos[i], $urandom);
      end
      wait_idle();
      // random phases
      for (int ph = 0; ph < 8; ph++) begin
         n = int'(counts[ph]);
         calm = (ph == 2);
         hold_go = (ph == 4);
         set_node_count(9'(n));
         for (int i = 0; i < 45; i++) begin
            op = $urandom_range(0, 99);
            if (op < 12) begin
               queue_item(OP_WRITE, 8'($urandom_range(0, 255)), $urandom, $urandom);
            end else if (op < 24) begin
               queue_item(OP_READ, 8'($urandom_range(0, 255)), $urandom, $urandom);
            end else if (op < 27) begin
               queue_item(2'd3, 8'($urandom_range(0, 255)), $urandom, $urandom);
            end else begin
               queue_item(OP_INTERP, 8'($urandom_range(0, 255)), pick_query(n, shadow_pos),
                          $urandom);
            end
            if (pending_items[$].opcode == OP_WRITE) begin
               shadow_pos[pending_items[$].node_index] = pending_items[$].position_in;
            end
         end
         wait_idle();
      end
      calm = 1'b0;
      set_node_count(9'd256);
      wait_idle();
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("profile_parabolic_interpolator_core test passed");
      end else begin
         $display("profile_parabolic_interpolator_core test failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("profile_parabolic_interpolator_core test failed");
      $finish;
   end

endmodule
